// ===== sv/mhic_pkg.sv =====
// shared constants and codes for the manifest header identity check
`timescale 1ns / 1ps

package mhic_pkg;

	// section header magic words, little-endian on the wire
	localparam logic [31:0] MAGIC_ONE = 32'h71F6_17D0;
	localparam logic [31:0] MAGIC_TWO = 32'h1F48_12BE;

	// configuration register indexes
	localparam logic REG_EXPECTED_DEPOT = 1'b0;
	localparam logic REG_EXPECTED_GID   = 1'b1;

	// protobuf wire types that the parser accepts
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LENGTH  = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	// which captured value a varint record feeds
	typedef enum logic [1:0] {
		FIELD_OTHER = 2'd0,
		FIELD_DEPOT = 2'd1,
		FIELD_GID   = 2'd2
	} field_kind_t;

	// a varint may span at most this many bytes
	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

endpackage

// ===== sv/mhic_if.sv =====
// byte and verdict channel interfaces
`timescale 1ns / 1ps

interface mhic_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface mhic_verdict_if;
	logic valid;
	logic ready;
	logic match;
	logic malformed;

	modport source (output valid, output match, output malformed, input ready);
	modport sink (input valid, input match, input malformed, output ready);
endinterface

// ===== sv/manifest_header_identity_check_unit.sv =====
// manifest header identity check: streaming header and metadata parser
//
//  channel   dir  beat contents              when
//  data      in   data_byte, last            one file byte per beat
//  verdict   out  match, malformed           one beat per byte flagged last
//  cfg_*     in   cfg_we, cfg_index, cfg_data  register write, no handshake
//
// While no verdict stalls, one byte is taken every cycle; the parser state
// update is a single pass from the input register to the state and
// verdict registers, which load a verdict as its last byte leaves.
// Reset clears the parser; it also returns to its reset state after each
// verdict. A stalled verdict holds the input register, then the input side.
`timescale 1ns / 1ps

module manifest_header_identity_check_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [63:0]          cfg_data,
	mhic_byte_if.sink            data,
	mhic_verdict_if.source       verdict
);

	typedef enum logic [3:0] {
		PH_H1_MAGIC = 4'd0,
		PH_H1_LEN   = 4'd1,
		PH_SKIP     = 4'd2,
		PH_H2_MAGIC = 4'd3,
		PH_H2_LEN   = 4'd4,
		PH_TAG      = 4'd5,
		PH_VALUE    = 4'd6,
		PH_LENV     = 4'd7,
		PH_DATA     = 4'd8,
		PH_DONE     = 4'd9
	} phase_t;

	// configuration registers
	logic [31:0] expected_depot_q;
	logic [63:0] expected_gid_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// parser state
	phase_t                 phase_q, phase_d;
	logic [1:0]             word_bytes_q, word_bytes_d;
	logic [31:0]            word_accum_q, word_accum_d;
	logic [31:0]            skip_left_q, skip_left_d;
	logic [31:0]            meta_left_q, meta_left_d;
	logic [63:0]            varint_accum_q, varint_accum_d;
	logic [3:0]             varint_count_q, varint_count_d;
	mhic_pkg::field_kind_t  field_kind_q, field_kind_d;
	logic [31:0]            seen_depot_q, seen_depot_d;
	logic [63:0]            seen_gid_q, seen_gid_d;
	logic                   failed_q, failed_d;

	// verdict register
	logic out_valid_q;
	logic match_q;
	logic malformed_q;

	logic        advance;
	logic        take_s1;
	logic [31:0] word_new;
	logic [31:0] meta_dec;
	logic [5:0]  shamt;
	logic [63:0] vnew;
	logic        parse_ok;
	logic        id_match;

	// handshake: the input stage moves whenever the verdict register is free
	assign advance     = !out_valid_q || verdict.ready;
	assign data.ready  = !valid_s1 || advance;
	assign take_s1     = valid_s1 && advance;

	assign verdict.valid     = out_valid_q;
	assign verdict.match     = match_q;
	assign verdict.malformed = malformed_q;

	// datapath helpers
	assign meta_dec   = meta_left_q - 32'd1;
	assign shamt      = 6'(varint_count_q) * 6'd7;
	assign vnew       = varint_accum_q | (64'(byte_s1[6:0]) << shamt);

	always_comb begin
		word_new = word_accum_q;
		word_new[8 * word_bytes_q +: 8] = byte_s1;
	end

	// next parser state for the byte in the input stage
	always_comb begin
		phase_d        = phase_q;
		word_bytes_d   = word_bytes_q;
		word_accum_d   = word_accum_q;
		skip_left_d    = skip_left_q;
		meta_left_d    = meta_left_q;
		varint_accum_d = varint_accum_q;
		varint_count_d = varint_count_q;
		field_kind_d   = field_kind_q;
		seen_depot_d   = seen_depot_q;
		seen_gid_d     = seen_gid_q;
		failed_d       = failed_q;

		if (!failed_q && phase_q != PH_DONE) begin
			case (phase_q)
				PH_H1_MAGIC, PH_H1_LEN, PH_H2_MAGIC, PH_H2_LEN: begin
					if (word_bytes_q == 2'd3) begin
						word_bytes_d = 2'd0;
						word_accum_d = 32'd0;
						case (phase_q)
							PH_H1_MAGIC: begin
								if (word_new != mhic_pkg::MAGIC_ONE) failed_d = 1'b1;
								else phase_d = PH_H1_LEN;
							end
							PH_H1_LEN: begin
								skip_left_d = word_new;
								phase_d = (word_new != 32'd0) ? PH_SKIP : PH_H2_MAGIC;
							end
							PH_H2_MAGIC: begin
								if (word_new != mhic_pkg::MAGIC_TWO) failed_d = 1'b1;
								else phase_d = PH_H2_LEN;
							end
							default: begin
								meta_left_d  = word_new;
								seen_depot_d = 32'd0;
								seen_gid_d   = 64'd0;
								phase_d = (word_new != 32'd0) ? PH_TAG : PH_DONE;
							end
						endcase
					end else begin
						word_bytes_d = word_bytes_q + 2'd1;
						word_accum_d = word_new;
					end
				end
				PH_SKIP: begin
					skip_left_d = skip_left_q - 32'd1;
					if (skip_left_q == 32'd1) phase_d = PH_H2_MAGIC;
				end
				PH_TAG, PH_VALUE, PH_LENV: begin
					meta_left_d = meta_dec;
					if (byte_s1[7]) begin
						// continuation byte
						varint_accum_d = vnew;
						varint_count_d = varint_count_q + 4'd1;
						if (varint_count_q + 4'd1 >= mhic_pkg::VARINT_MAX_BYTES ||
								meta_dec == 32'd0) begin
							failed_d = 1'b1;
						end
					end else begin
						varint_accum_d = 64'd0;
						varint_count_d = 4'd0;
						case (phase_q)
							PH_TAG: begin
								// tag: pick the field and dispatch on wire type
								if (vnew[63:3] == 61'd1) field_kind_d = mhic_pkg::FIELD_DEPOT;
								else if (vnew[63:3] == 61'd2) field_kind_d = mhic_pkg::FIELD_GID;
								else field_kind_d = mhic_pkg::FIELD_OTHER;
								case (vnew[2:0])
									mhic_pkg::WIRE_VARINT: begin
										if (meta_dec == 32'd0) failed_d = 1'b1;
										else phase_d = PH_VALUE;
									end
									mhic_pkg::WIRE_FIXED64: begin
										if (meta_dec < 32'd8) failed_d = 1'b1;
										else begin
											skip_left_d = 32'd8;
											phase_d = PH_DATA;
										end
									end
									mhic_pkg::WIRE_LENGTH: begin
										if (meta_dec == 32'd0) failed_d = 1'b1;
										else phase_d = PH_LENV;
									end
									mhic_pkg::WIRE_FIXED32: begin
										if (meta_dec < 32'd4) failed_d = 1'b1;
										else begin
											skip_left_d = 32'd4;
											phase_d = PH_DATA;
										end
									end
									default: failed_d = 1'b1;
								endcase
							end
							PH_VALUE: begin
								// varint value: capture depot or gid, last one wins
								if (field_kind_q == mhic_pkg::FIELD_DEPOT) seen_depot_d = vnew[31:0];
								if (field_kind_q == mhic_pkg::FIELD_GID) seen_gid_d = vnew;
								phase_d = (meta_dec == 32'd0) ? PH_DONE : PH_TAG;
							end
							default: begin
								// payload length of a length-delimited record
								if (vnew > {32'd0, meta_dec}) failed_d = 1'b1;
								else if (vnew == 64'd0) begin
									phase_d = (meta_dec == 32'd0) ? PH_DONE : PH_TAG;
								end else begin
									skip_left_d = vnew[31:0];
									phase_d = PH_DATA;
								end
							end
						endcase
					end
				end
				PH_DATA: begin
					meta_left_d = meta_dec;
					skip_left_d = skip_left_q - 32'd1;
					if (skip_left_q == 32'd1) begin
						phase_d = (meta_dec == 32'd0) ? PH_DONE : PH_TAG;
					end
				end
				default: ;
			endcase
		end
	end

	// verdict for a last byte
	assign parse_ok = !failed_d && phase_d == PH_DONE;
	assign id_match = seen_depot_d == expected_depot_q && seen_gid_d == expected_gid_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_depot_q <= 32'd0;
			expected_gid_q   <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				mhic_pkg::REG_EXPECTED_DEPOT: expected_depot_q <= cfg_data[31:0];
				mhic_pkg::REG_EXPECTED_GID:   expected_gid_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (data.ready && data.valid) begin
			byte_s1 <= data.data_byte;
			last_s1 <= data.last;
		end
	end

	// parser state, cleared after each verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_H1_MAGIC;
			word_bytes_q   <= 2'd0;
			word_accum_q   <= 32'd0;
			skip_left_q    <= 32'd0;
			meta_left_q    <= 32'd0;
			varint_accum_q <= 64'd0;
			varint_count_q <= 4'd0;
			field_kind_q   <= mhic_pkg::FIELD_OTHER;
			seen_depot_q   <= 32'd0;
			seen_gid_q     <= 64'd0;
			failed_q       <= 1'b0;
		end else if (take_s1) begin
			if (last_s1) begin
				phase_q        <= PH_H1_MAGIC;
				word_bytes_q   <= 2'd0;
				word_accum_q   <= 32'd0;
				skip_left_q    <= 32'd0;
				meta_left_q    <= 32'd0;
				varint_accum_q <= 64'd0;
				varint_count_q <= 4'd0;
				field_kind_q   <= mhic_pkg::FIELD_OTHER;
				seen_depot_q   <= 32'd0;
				seen_gid_q     <= 64'd0;
				failed_q       <= 1'b0;
			end else begin
				phase_q        <= phase_d;
				word_bytes_q   <= word_bytes_d;
				word_accum_q   <= word_accum_d;
				skip_left_q    <= skip_left_d;
				meta_left_q    <= meta_left_d;
				varint_accum_q <= varint_accum_d;
				varint_count_q <= varint_count_d;
				field_kind_q   <= field_kind_d;
				seen_depot_q   <= seen_depot_d;
				seen_gid_q     <= seen_gid_d;
				failed_q       <= failed_d;
			end
		end
	end

	// verdict register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	// verdict register payload
	always_ff @(posedge clk) begin
		if (take_s1 && last_s1) begin
			match_q     <= parse_ok && id_match;
			malformed_q <= !parse_ok;
		end
	end

endmodule
